>>> src/msmu_pkg.sv
package msmu_pkg;

   localparam int CHANNELS = 8;
   localparam int CHAN_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   localparam logic [1:0] MODE_START  = 2'd0;
   localparam logic [1:0] MODE_UPDATE = 2'd1;
   localparam logic [1:0] MODE_SAMPLE = 2'd2;
   localparam logic [1:0] MODE_EMIT   = 2'd3;

   localparam logic [1:0] REG_MASTER_GAIN_ADDR = 2'd0;
   localparam logic [7:0] MASTER_GAIN_RESET    = 8'd255;

   localparam logic signed [20:0] ACC_MAX = 21'sd524287;
   localparam logic signed [20:0] ACC_MIN = -21'sd524288;
   localparam logic signed [20:0] OUT_MAX = 21'sd32767;
   localparam logic signed [20:0] OUT_MIN = -21'sd32768;

   typedef struct packed {
      logic [1:0]        mode;
      logic [2:0]        chan_index;
      logic [4:0]        left_level;
      logic [4:0]        right_level;
      logic              audible;
      logic [19:0]       sample_length;
      logic signed [7:0] sample;
   } item_type;

endpackage

>>> src/multichannel_sample_mixer_unit.sv
// Stereo mixer for up to eight voices of unsigned 8-bit samples. Each input transaction
// (start, volume update, sample or frame emit) yields exactly one result transaction,
// and the block takes one transaction per clock cycle while its output register is empty or
// being popped: the channel state and both accumulators are read and updated in the same
// cycle of the execute stage. A result passes through a two-entry queue between decode
// and execute and one output register that refills as it is popped.
// The master gain register sits at byte address 0 of the configuration port and
// should be written only while no transaction is in flight.
module multichannel_sample_mixer_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic [1:0]         req_mode,
   input  logic [2:0]         req_chan_index,
   input  logic signed [10:0] req_left_volume,
   input  logic signed [10:0] req_right_volume,
   input  logic [19:0]        req_sample_length,
   input  logic [7:0]         req_sample_byte,
   output logic               empty,
   input  logic               pop,
   output logic               rsp_frame_valid,
   output logic signed [7:0]  rsp_left_out,
   output logic signed [7:0]  rsp_right_out,
   output logic               rsp_chan_active,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [1:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   msmu_pkg::item_type front_item;
   msmu_pkg::item_type back_item;
   logic               q_empty;
   logic               q_pop;
   logic [7:0]         master_gain_ff;
   logic [7:0]         master_gain_in;
   logic               csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && (paddr == msmu_pkg::REG_MASTER_GAIN_ADDR);
   assign prdata    = (paddr == msmu_pkg::REG_MASTER_GAIN_ADDR) ? {24'd0, master_gain_ff}
                                                                : 32'd0;
   assign master_gain_in = csr_write ? pwdata[7:0] : master_gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         master_gain_ff <= msmu_pkg::MASTER_GAIN_RESET;
      end else begin
         master_gain_ff <= master_gain_in;
      end
   end

   msmu_front u_front (
      .req_mode          (req_mode),
      .req_chan_index    (req_chan_index),
      .req_left_volume   (req_left_volume),
      .req_right_volume  (req_right_volume),
      .req_sample_length (req_sample_length),
      .req_sample_byte   (req_sample_byte),
      .item              (front_item)
   );

   msmu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (front_item),
      .full      (full),
      .pop       (q_pop),
      .pop_item  (back_item),
      .empty     (q_empty)
   );

   msmu_back u_back (
      .clock           (clock),
      .reset           (reset),
      .master_gain     (master_gain_ff),
      .item            (back_item),
      .item_empty      (q_empty),
      .item_pop        (q_pop),
      .empty           (empty),
      .pop             (pop),
      .rsp_frame_valid (rsp_frame_valid),
      .rsp_left_out    (rsp_left_out),
      .rsp_right_out   (rsp_right_out),
      .rsp_chan_active (rsp_chan_active)
   );

endmodule

>>> src/msmu_front.sv
module msmu_front (
   input  logic [1:0]         req_mode,
   input  logic [2:0]         req_chan_index,
   input  logic signed [10:0] req_left_volume,
   input  logic signed [10:0] req_right_volume,
   input  logic [19:0]        req_sample_length,
   input  logic [7:0]         req_sample_byte,
   output msmu_pkg::item_type item
);

   logic [7:0] left_clamp;
   logic [7:0] right_clamp;

   // clamp raw volume to 0..255
   always_comb begin
      priority if (req_left_volume < 0) begin
         left_clamp = 8'd0;
      end else if (req_left_volume > 11'sd255) begin
         left_clamp = 8'd255;
      end else begin
         left_clamp = req_left_volume[7:0];
      end
   end

   always_comb begin
      priority if (req_right_volume < 0) begin
         right_clamp = 8'd0;
      end else if (req_right_volume > 11'sd255) begin
         right_clamp = 8'd255;
      end else begin
         right_clamp = req_right_volume[7:0];
      end
   end

   always_comb begin
      item.mode          = req_mode;
      item.chan_index    = req_chan_index;
      item.left_level    = left_clamp[7:3];
      item.right_level   = right_clamp[7:3];
      item.audible       = (left_clamp != 8'd0) || (right_clamp != 8'd0);
      item.sample_length = req_sample_length;
      // remove offset 128
      item.sample        = {~req_sample_byte[7], req_sample_byte[6:0]};
   end

endmodule

>>> src/msmu_queue.sv
module msmu_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  msmu_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output msmu_pkg::item_type pop_item,
   output logic               empty
);

   msmu_pkg::item_type entry_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       do_push;
   logic       do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> src/msmu_back.sv
module msmu_back (
   input  logic               clock,
   input  logic               reset,
   input  logic [7:0]         master_gain,
   input  msmu_pkg::item_type item,
   input  logic               item_empty,
   output logic               item_pop,
   output logic               empty,
   input  logic               pop,
   output logic               rsp_frame_valid,
   output logic signed [7:0]  rsp_left_out,
   output logic signed [7:0]  rsp_right_out,
   output logic               rsp_chan_active
);

   localparam int N = msmu_pkg::CHANNELS;

   logic        active_ff      [N];
   logic        active_in      [N];
   logic        audible_ff     [N];
   logic        audible_in     [N];
   logic [4:0]  left_level_ff  [N];
   logic [4:0]  left_level_in  [N];
   logic [4:0]  right_level_ff [N];
   logic [4:0]  right_level_in [N];
   logic [19:0] remain_ff      [N];
   logic [19:0] remain_in      [N];

   logic signed [19:0] left_accum_ff;
   logic signed [19:0] left_accum_in;
   logic signed [19:0] right_accum_ff;
   logic signed [19:0] right_accum_in;

   logic              out_valid_ff;
   logic              frame_valid_ff;
   logic              frame_valid_in;
   logic signed [7:0] left_out_ff;
   logic signed [7:0] left_out_in;
   logic signed [7:0] right_out_ff;
   logic signed [7:0] right_out_in;
   logic              chan_active_ff;
   logic              chan_active_in;

   logic                                 fire;
   logic [msmu_pkg::CHAN_IDX_W-1:0]      idx;
   logic                                 ok;
   logic signed [13:0]                   left_prod;
   logic signed [13:0]                   right_prod;
   logic signed [20:0]                   left_sum;
   logic signed [20:0]                   right_sum;
   logic signed [28:0]                   left_scaled;
   logic signed [28:0]                   right_scaled;
   logic signed [20:0]                   left_shift;
   logic signed [20:0]                   right_shift;
   logic signed [20:0]                   left_sat;
   logic signed [20:0]                   right_sat;
   logic [19:0]                          remain_dec;

   assign fire     = !item_empty && (!out_valid_ff || pop);
   assign item_pop = fire;
   assign empty    = !out_valid_ff;

   assign rsp_frame_valid = frame_valid_ff;
   assign rsp_left_out    = left_out_ff;
   assign rsp_right_out   = right_out_ff;
   assign rsp_chan_active = chan_active_ff;

   assign idx = msmu_pkg::CHAN_IDX_W'(item.chan_index);
   assign ok  = 32'(item.chan_index) < N;

   // sample contribution and saturating accumulate
   always_comb begin
      left_prod  = item.sample * $signed({1'b0, left_level_ff[idx]});
      right_prod = item.sample * $signed({1'b0, right_level_ff[idx]});
      left_sum   = 21'(left_accum_ff) + (21'(left_prod) <<< 3);
      right_sum  = 21'(right_accum_ff) + (21'(right_prod) <<< 3);
      if (left_sum > msmu_pkg::ACC_MAX) begin
         left_sum = msmu_pkg::ACC_MAX;
      end else if (left_sum < msmu_pkg::ACC_MIN) begin
         left_sum = msmu_pkg::ACC_MIN;
      end
      if (right_sum > msmu_pkg::ACC_MAX) begin
         right_sum = msmu_pkg::ACC_MAX;
      end else if (right_sum < msmu_pkg::ACC_MIN) begin
         right_sum = msmu_pkg::ACC_MIN;
      end
   end

   // frame output: gain, floor shift, saturate to 16 bits
   always_comb begin
      left_scaled  = left_accum_ff * $signed({1'b0, master_gain});
      right_scaled = right_accum_ff * $signed({1'b0, master_gain});
      left_shift   = left_scaled[28:8];
      right_shift  = right_scaled[28:8];
      priority if (left_shift > msmu_pkg::OUT_MAX) begin
         left_sat = msmu_pkg::OUT_MAX;
      end else if (left_shift < msmu_pkg::OUT_MIN) begin
         left_sat = msmu_pkg::OUT_MIN;
      end else begin
         left_sat = left_shift;
      end
      priority if (right_shift > msmu_pkg::OUT_MAX) begin
         right_sat = msmu_pkg::OUT_MAX;
      end else if (right_shift < msmu_pkg::OUT_MIN) begin
         right_sat = msmu_pkg::OUT_MIN;
      end else begin
         right_sat = right_shift;
      end
   end

   always_comb begin
      active_in      = active_ff;
      audible_in     = audible_ff;
      left_level_in  = left_level_ff;
      right_level_in = right_level_ff;
      remain_in      = remain_ff;
      left_accum_in  = left_accum_ff;
      right_accum_in = right_accum_ff;
      frame_valid_in = frame_valid_ff;
      left_out_in    = left_out_ff;
      right_out_in   = right_out_ff;
      chan_active_in = chan_active_ff;
      remain_dec     = (remain_ff[idx] != 20'd0) ? remain_ff[idx] - 20'd1 : remain_ff[idx];
      if (fire) begin
         frame_valid_in = 1'b0;
         left_out_in    = 8'sd0;
         right_out_in   = 8'sd0;
         chan_active_in = 1'b0;
         unique case (item.mode)
            msmu_pkg::MODE_EMIT: begin
               frame_valid_in = 1'b1;
               left_out_in    = left_sat[15:8];
               right_out_in   = right_sat[15:8];
               left_accum_in  = 20'sd0;
               right_accum_in = 20'sd0;
            end
            msmu_pkg::MODE_START: begin
               if (ok) begin
                  left_level_in[idx]  = item.left_level;
                  right_level_in[idx] = item.right_level;
                  audible_in[idx]     = item.audible;
                  remain_in[idx]      = item.sample_length;
                  active_in[idx]      = item.sample_length != 20'd0;
                  chan_active_in      = item.sample_length != 20'd0;
               end
            end
            msmu_pkg::MODE_UPDATE: begin
               if (ok) begin
                  left_level_in[idx]  = item.left_level;
                  right_level_in[idx] = item.right_level;
                  audible_in[idx]     = item.audible;
                  chan_active_in      = active_ff[idx];
               end
            end
            msmu_pkg::MODE_SAMPLE: begin
               if (ok) begin
                  chan_active_in = active_ff[idx];
                  if (active_ff[idx] && audible_ff[idx]) begin
                     left_accum_in  = left_sum[19:0];
                     right_accum_in = right_sum[19:0];
                     remain_in[idx] = remain_dec;
                     active_in[idx] = remain_dec != 20'd0;
                     chan_active_in = remain_dec != 20'd0;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < N; i++) begin
            active_ff[i]      <= 1'b0;
            audible_ff[i]     <= 1'b0;
            left_level_ff[i]  <= 5'd0;
            right_level_ff[i] <= 5'd0;
            remain_ff[i]      <= 20'd0;
         end
         left_accum_ff  <= 20'sd0;
         right_accum_ff <= 20'sd0;
         out_valid_ff   <= 1'b0;
      end else begin
         active_ff      <= active_in;
         audible_ff     <= audible_in;
         left_level_ff  <= left_level_in;
         right_level_ff <= right_level_in;
         remain_ff      <= remain_in;
         left_accum_ff  <= left_accum_in;
         right_accum_ff <= right_accum_in;
         if (fire) begin
            out_valid_ff <= 1'b1;
         end else if (pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      frame_valid_ff <= frame_valid_in;
      left_out_ff    <= left_out_in;
      right_out_ff   <= right_out_in;
      chan_active_ff <= chan_active_in;
   end

endmodule

>>> sim/multichannel_sample_mixer_unit_test.sv
`timescale 1ns / 1ps

module multichannel_sample_mixer_unit_test;

   typedef struct {
      logic [1:0]         mode;
      logic [2:0]         chan;
      logic signed [10:0] left_vol;
      logic signed [10:0] right_vol;
      logic [19:0]        length;
      logic [7:0]         sample;
   } mix_req_type;

   typedef struct {
      logic              frame_valid;
      logic signed [7:0] left_out;
      logic signed [7:0] right_out;
      logic              chan_active;
   } mix_result_type;

   localparam int ACCUM_HI = 524287;
   localparam int ACCUM_LO = -524288;

   class mixer_scoreboard_type;
      bit [7:0]       gain = msmu_pkg::MASTER_GAIN_RESET;
      bit             playing [msmu_pkg::CHANNELS];
      bit             audible [msmu_pkg::CHANNELS];
      bit [4:0]       level_l [msmu_pkg::CHANNELS];
      bit [4:0]       level_r [msmu_pkg::CHANNELS];
      bit [19:0]      samples_left [msmu_pkg::CHANNELS];
      int             accum_l;
      int             accum_r;
      mix_result_type frame_q[$];
      int             errors;

      function int pending();
         return frame_q.size();
      endfunction

      function bit [4:0] clamp_level(logic signed [10:0] raw, output bit loud);
         int v;
         v = raw;
         if (v > 255) v = 255;
         if (v < 0) v = 0;
         loud = (v > 0);
         return v[7:3];
      endfunction

      function void load_volumes(int ch, logic signed [10:0] lv, logic signed [10:0] rv);
         bit loud_l;
         bit loud_r;
         level_l[ch] = clamp_level(lv, loud_l);
         level_r[ch] = clamp_level(rv, loud_r);
         audible[ch] = loud_l | loud_r;
      endfunction

      function int sat_accum(int acc, int add);
         int s;
         s = acc + add;
         if (s > ACCUM_HI) s = ACCUM_HI;
         if (s < ACCUM_LO) s = ACCUM_LO;
         return s;
      endfunction

      function logic [7:0] output_byte(int acc);
         longint p;
         longint v;
         p = longint'(acc) * longint'(gain);
         v = p >>> 8;
         if (v > 32767) v = 32767;
         if (v < -32768) v = -32768;
         return v[15:8];
      endfunction

      function void note_item(mix_req_type r);
         mix_result_type e;
         int ch;
         int smp;
         e = '{frame_valid: 1'b0, left_out: 8'sd0, right_out: 8'sd0, chan_active: 1'b0};
         ch = r.chan;
         smp = int'(r.sample) - 128;
         case (r.mode)
            msmu_pkg::MODE_EMIT: begin
               e.frame_valid = 1'b1;
               e.left_out = output_byte(accum_l);
               e.right_out = output_byte(accum_r);
               accum_l = 0;
               accum_r = 0;
            end
            msmu_pkg::MODE_START: begin
               load_volumes(ch, r.left_vol, r.right_vol);
               samples_left[ch] = r.length;
               playing[ch] = (r.length != 0);
            end
            msmu_pkg::MODE_UPDATE: load_volumes(ch, r.left_vol, r.right_vol);
            msmu_pkg::MODE_SAMPLE: begin
               if (playing[ch] && audible[ch]) begin
                  accum_l = sat_accum(accum_l, smp * int'(level_l[ch]) * 8);
                  accum_r = sat_accum(accum_r, smp * int'(level_r[ch]) * 8);
                  if (samples_left[ch] != 0) samples_left[ch]--;
                  if (samples_left[ch] == 0) playing[ch] = 1'b0;
               end
            end
            default: begin
            end
         endcase
         if (r.mode != msmu_pkg::MODE_EMIT) e.chan_active = playing[ch];
         frame_q.push_back(e);
      endfunction

      function void check_result(mix_result_type got);
         mix_result_type e;
         if (frame_q.size() == 0) begin
            $error("unexpected result transaction");
            errors++;
            return;
         end
         e = frame_q.pop_front();
         if (got.frame_valid !== e.frame_valid) begin
            $error("frame_valid: expected %0d, actual %0d", e.frame_valid, got.frame_valid);
            errors++;
         end
         if (got.left_out !== e.left_out) begin
            $error("left_out: expected %0d, actual %0d", e.left_out, got.left_out);
            errors++;
         end
         if (got.right_out !== e.right_out) begin
            $error("right_out: expected %0d, actual %0d", e.right_out, got.right_out);
            errors++;
         end
         if (got.chan_active !== e.chan_active) begin
            $error("chan_active: expected %0d, actual %0d", e.chan_active, got.chan_active);
            errors++;
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset;
   logic               push;
   logic               full;
   logic [1:0]         req_mode;
   logic [2:0]         req_chan_index;
   logic signed [10:0] req_left_volume;
   logic signed [10:0] req_right_volume;
   logic [19:0]        req_sample_length;
   logic [7:0]         req_sample_byte;
   logic               empty;
   logic               pop;
   logic               rsp_frame_valid;
   logic signed [7:0]  rsp_left_out;
   logic signed [7:0]  rsp_right_out;
   logic               rsp_chan_active;
   logic               psel;
   logic               penable;
   logic               pwrite;
   logic [1:0]         paddr;
   logic [31:0]        pwdata;
   logic [31:0]        prdata;
   logic               pready;

   mixer_scoreboard_type sb = new;
   bit tx_idle_on = 1'b1;
   bit rx_idle_on = 1'b1;
   int rx_hold;
   int items_sent;

   multichannel_sample_mixer_unit u_top (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_mode(req_mode),
      .req_chan_index(req_chan_index),
      .req_left_volume(req_left_volume),
      .req_right_volume(req_right_volume),
      .req_sample_length(req_sample_length),
      .req_sample_byte(req_sample_byte),
      .empty(empty),
      .pop(pop),
      .rsp_frame_valid(rsp_frame_valid),
      .rsp_left_out(rsp_left_out),
      .rsp_right_out(rsp_right_out),
      .rsp_chan_active(rsp_chan_active),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always #2 clock = ~clock;

   // transaction monitor
   always @(posedge clock) begin
      mix_req_type    r;
      mix_result_type got;
      if (!reset) begin
         if (push && !full) begin
            r.mode = req_mode;
            r.chan = req_chan_index;
            r.left_vol = req_left_volume;
            r.right_vol = req_right_volume;
            r.length = req_sample_length;
            r.sample = req_sample_byte;
            sb.note_item(r);
         end
         if (pop && !empty) begin
            got.frame_valid = rsp_frame_valid;
            got.left_out = rsp_left_out;
            got.right_out = rsp_right_out;
            got.chan_active = rsp_chan_active;
            sb.check_result(got);
         end
      end
   end

   // result side
   initial begin
      pop <= 1'b0;
      @(posedge clock);
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (rx_hold > 0) begin
            pop <= 1'b0;
            repeat (rx_hold) @(posedge clock);
            rx_hold = 0;
         end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
            pop <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end else begin
            pop <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin
      #3_000_000;
      $display("multichannel_sample_mixer_unit_test: errors");
      $finish;
   end

   function automatic mix_req_type make_item(logic [1:0] mode, int ch, int lv, int rv,
                                             int len, int smp);
      mix_req_type r;
      r.mode = mode;
      r.chan = ch[2:0];
      r.left_vol = lv[10:0];
      r.right_vol = rv[10:0];
      r.length = len[19:0];
      r.sample = smp[7:0];
      return r;
   endfunction

   function automatic int rand_volume();
      bit [31:0] v;
      v = $urandom();
      if ($urandom_range(0, 3) == 0) return int'($signed(v[10:0]));
      return $urandom_range(0, 255);
   endfunction

   task automatic idle_sender(input int n);
      push <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic send_item(input mix_req_type r);
      if (tx_idle_on && $urandom_range(0, 3) == 0) idle_sender($urandom_range(1, 8));
      req_mode <= r.mode;
      req_chan_index <= r.chan;
      req_left_volume <= r.left_vol;
      req_right_volume <= r.right_vol;
      req_sample_length <= r.length;
      req_sample_byte <= r.sample;
      if (push !== 1'b1) push <= 1'b1;
      do @(posedge clock); while (full !== 1'b0);
      items_sent++;
   endtask

   task automatic drain_results();
      push <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic csr_write(input logic [1:0] addr, input logic [31:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_read(input logic [1:0] addr, output logic [31:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= addr;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      data = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_gain_readback();
      logic [31:0] rd;
      csr_read(msmu_pkg::REG_MASTER_GAIN_ADDR, rd);
      if (rd !== {24'd0, sb.gain}) begin
         $error("master_gain: expected %0d, actual %0d", sb.gain, rd);
         sb.errors++;
      end
   endtask

   task automatic set_gain(input bit [7:0] g);
      logic [31:0] w;
      w = $urandom();
      w[7:0] = g;
      csr_write(msmu_pkg::REG_MASTER_GAIN_ADDR, w);
      sb.gain = g;
      check_gain_readback();
   endtask

   // start one voice, then send a short run of samples and volume updates
   task automatic play_voice();
      int ch;
      int len;
      int n;
      int pick;
      ch = $urandom_range(0, msmu_pkg::CHANNELS - 1);
      len = ($urandom_range(0, 15) == 0) ? int'($urandom() & 32'hFFFFF) : $urandom_range(0, 12);
      send_item(make_item(msmu_pkg::MODE_START, ch, rand_volume(), rand_volume(), len,
                          $urandom()));
      n = $urandom_range(1, 16);
      repeat (n) begin
         pick = $urandom_range(0, 19);
         if (pick < 2)
            send_item(make_item(msmu_pkg::MODE_UPDATE, ch, rand_volume(), rand_volume(),
                                $urandom(), $urandom()));
         else if (pick < 5)
            send_item(make_item(msmu_pkg::MODE_SAMPLE,
                                $urandom_range(0, msmu_pkg::CHANNELS - 1), $urandom(),
                                $urandom(), $urandom(), $urandom()));
         else
            send_item(make_item(msmu_pkg::MODE_SAMPLE, ch, $urandom(), $urandom(),
                                $urandom(), $urandom()));
      end
      if ($urandom_range(0, 1) == 0)
         send_item(make_item(msmu_pkg::MODE_EMIT, $urandom(), $urandom(), $urandom(),
                             $urandom(), $urandom()));
   endtask

   // full volume run of one sign, drives the accumulators toward saturation
   task automatic play_loud_run();
      int ch;
      bit up;
      ch = $urandom_range(0, msmu_pkg::CHANNELS - 1);
      up = 1'($urandom_range(0, 1));
      send_item(make_item(msmu_pkg::MODE_START, ch, $urandom_range(248, 1023),
                          $urandom_range(248, 1023), $urandom_range(30, 60), 0));
      repeat ($urandom_range(18, 24))
         send_item(make_item(msmu_pkg::MODE_SAMPLE, ch, 0, 0, 0,
                             up ? $urandom_range(200, 255) : $urandom_range(0, 55)));
      send_item(make_item(msmu_pkg::MODE_EMIT, ch, 0, 0, 0, 0));
   endtask

   task automatic send_noise();
      send_item(make_item(2'($urandom_range(0, 3)), $urandom(), $urandom(), $urandom(),
                          $urandom(), $urandom()));
   endtask

   initial begin
      bit [7:0] phase_gain [5];
      int phase_end;
      int pick;
      bit paused;
      reset <= 1'b1;
      push <= 1'b0;
      req_mode <= msmu_pkg::MODE_START;
      req_chan_index <= '0;
      req_left_volume <= '0;
      req_right_volume <= '0;
      req_sample_length <= '0;
      req_sample_byte <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      phase_gain[0] = 8'd0;
      phase_gain[1] = 8'd255;
      phase_gain[2] = 8'd1;
      phase_gain[3] = 8'd128;
      phase_gain[4] = 8'($urandom_range(2, 254));
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_gain_readback();

      // directed
      send_item(make_item(msmu_pkg::MODE_START, 0, 1023, -1024, 3, 0));
      send_item(make_item(msmu_pkg::MODE_SAMPLE, 0, 0, 0, 0, 255));
      send_item(make_item(msmu_pkg::MODE_SAMPLE, 0, 0, 0, 0, 0));
      send_item(make_item(msmu_pkg::MODE_EMIT, 0, 0, 0, 0, 0));
      send_item(make_item(msmu_pkg::MODE_SAMPLE, 0, 0, 0, 0, 128));
      send_item(make_item(msmu_pkg::MODE_SAMPLE, 0, 0, 0, 0, 77));
      send_item(make_item(msmu_pkg::MODE_UPDATE, 1, -1, 300, 0, 0));
      send_item(make_item(msmu_pkg::MODE_SAMPLE, 1, 0, 0, 0, 255));
      send_item(make_item(msmu_pkg::MODE_START, 2, 0, 0, 5, 0));
      send_item(make_item(msmu_pkg::MODE_SAMPLE, 2, 0, 0, 0, 255));
      send_item(make_item(msmu_pkg::MODE_UPDATE, 2, 7, -5, 0, 0));
      send_item(make_item(msmu_pkg::MODE_SAMPLE, 2, 0, 0, 0, 0));
      send_item(make_item(msmu_pkg::MODE_START, 2, 255, 255, 0, 0));
      send_item(make_item(msmu_pkg::MODE_START, 7, 1023, 1023, 20'hFFFFF, 0));
      send_item(make_item(msmu_pkg::MODE_SAMPLE, 7, 0, 0, 0, 0));
      send_item(make_item(msmu_pkg::MODE_SAMPLE, 7, 0, 0, 0, 255));
      send_item(make_item(msmu_pkg::MODE_EMIT, 7, 0, 0, 0, 0));
      send_item(make_item(msmu_pkg::MODE_EMIT, 0, 0, 0, 0, 0));

      // random phases, one master gain each
      for (int ph = 0; ph < 5; ph++) begin
         drain_results();
         repeat (4) @(posedge clock);
         set_gain(phase_gain[ph]);
         if (ph == 4) begin
            tx_idle_on = 1'b0;
            rx_idle_on = 1'b0;
         end
         if (ph == 1) rx_hold = 200;
         paused = 1'b0;
         phase_end = items_sent + 340;
         while (items_sent < phase_end) begin
            if (ph == 2 && !paused && items_sent >= phase_end - 170) begin
               drain_results();
               paused = 1'b1;
            end
            pick = $urandom_range(0, 19);
            if (pick < 12) play_voice();
            else if (pick < 15) play_loud_run();
            else send_noise();
         end
      end

      push <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (10) @(posedge clock);
      if (sb.errors == 0)
         $display("multichannel_sample_mixer_unit_test: clean");
      else
         $display("multichannel_sample_mixer_unit_test: errors");
      $finish;
   end

endmodule

>>> sim.f
src/msmu_pkg.sv
src/msmu_front.sv
src/msmu_queue.sv
src/msmu_back.sv
src/multichannel_sample_mixer_unit.sv
sim/multichannel_sample_mixer_unit_test.sv
